[rtl/core/dynamic_obstacle_collision_cost_assert.svh]
// Shared assertion macros for the collision cost block.
`ifndef DYNAMIC_OBSTACLE_COLLISION_COST_ASSERT_SVH
`define DYNAMIC_OBSTACLE_COLLISION_COST_ASSERT_SVH

// Same-cycle implication.
`define DOCC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("docc: same-cycle check failed");

// Next-cycle implication.
`define DOCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("docc: next-cycle check failed");

`endif

[rtl/core/docc_pkg.sv]
`timescale 1ns / 1ps

package docc_pkg;

  localparam int MAX_OBSTACLES_DEF = 16;
  localparam int MAX_POINTS_DEF    = 256;

  localparam int POS_W   = 24;
  localparam int VEL_W   = 16;
  localparam int LEN_W   = 16;
  localparam int TIME_W  = 16;
  localparam int COST_W  = 26;
  localparam int SUM_W   = 29;
  localparam int MV_W    = 33;
  localparam int DIFF_W  = 26;
  localparam int SQ_W    = 52;
  localparam int RAD_W   = 54;
  localparam int ROOT_W  = 27;
  localparam int REM_W   = 29;
  localparam int CLR_W   = 29;
  localparam int A_W     = 10;
  localparam int U_W     = 20;
  localparam int TERM_W  = 17;
  localparam int EXPP_W  = 35;
  localparam int FPROD_W = 45;
  localparam int FQ_W    = 37;
  localparam int STEP_W  = 6;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_POINT  = 2'd2;

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROBOT_RADIUS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RISK_FACTOR  = 1'b1;

  localparam logic [LEN_W-1:0]  ROBOT_RADIUS_RST = 16'd256;
  localparam logic [LEN_W-1:0]  RISK_FACTOR_RST  = 16'd256;
  localparam logic [COST_W-1:0] COLLISION_COST   = 26'd65536000;
  localparam logic [COST_W-1:0] COST_MAX         = {COST_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX          = {SUM_W{1'b1}};
  localparam logic [U_W-1:0]    U_LIMIT          = 20'd786432;
  localparam logic [EXPP_W-1:0] EXP_ROUND        = 35'd32768;

  localparam logic [STEP_W-1:0] ROOT_STEPS = 6'd27;
  localparam logic [STEP_W-1:0] QDIV_STEPS = 6'd10;
  localparam logic [STEP_W-1:0] FDIV_STEPS = 6'd37;

  typedef logic [3:0] cmd_code_t;
  localparam cmd_code_t CMD_NONE      = 4'd0;
  localparam cmd_code_t CMD_READ      = 4'd1;
  localparam cmd_code_t CMD_MOVE      = 4'd2;
  localparam cmd_code_t CMD_DIFF      = 4'd3;
  localparam cmd_code_t CMD_SQUARE    = 4'd4;
  localparam cmd_code_t CMD_ROOT_LD   = 4'd5;
  localparam cmd_code_t CMD_ROOT_STEP = 4'd6;
  localparam cmd_code_t CMD_EVAL      = 4'd7;
  localparam cmd_code_t CMD_QSTEP     = 4'd8;
  localparam cmd_code_t CMD_EXP_SQ    = 4'd9;
  localparam cmd_code_t CMD_EXP_MUL   = 4'd10;
  localparam cmd_code_t CMD_ACC       = 4'd11;
  localparam cmd_code_t CMD_FMUL      = 4'd12;
  localparam cmd_code_t CMD_FSTEP     = 4'd13;
  localparam cmd_code_t CMD_EMIT      = 4'd14;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic [LEN_W-1:0]        obstacle_radius;
    logic [LEN_W-1:0]        obstacle_spread;
    logic [TIME_W-1:0]       point_time;
    logic                    last_point;
  } item_t;

  typedef struct packed {
    logic [COST_W-1:0] path_cost;
    logic              collision;
  } result_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic [LEN_W-1:0]        radius;
    logic [LEN_W-1:0]        spread;
  } obstacle_t;

  typedef struct packed {
    logic      accept;
    cmd_code_t code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] item_op;
    logic       item_last;
    logic       count_zero;
    logic       idx_last;
    logic       skip;
    logic       pt_last;
    logic       hit;
    logic       out_free;
  } ctrl_sts_t;

  function automatic logic [TERM_W-1:0] exp_int(input logic [3:0] n);
    logic [TERM_W-1:0] v;
    case (n)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      4'd8:    v = 17'd22;
      4'd9:    v = 17'd8;
      4'd10:   v = 17'd3;
      4'd11:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  function automatic logic [TERM_W-1:0] exp_frac(input logic [3:0] n);
    logic [TERM_W-1:0] v;
    case (n)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd61565;
      4'd2:    v = 17'd57835;
      4'd3:    v = 17'd54331;
      4'd4:    v = 17'd51039;
      4'd5:    v = 17'd47947;
      4'd6:    v = 17'd45042;
      4'd7:    v = 17'd42313;
      4'd8:    v = 17'd39750;
      4'd9:    v = 17'd37341;
      4'd10:   v = 17'd35079;
      4'd11:   v = 17'd32954;
      4'd12:   v = 17'd30957;
      4'd13:   v = 17'd29081;
      4'd14:   v = 17'd27319;
      default: v = 17'd25664;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/dynamic_obstacle_collision_cost.sv]
// Dynamic obstacle collision cost.
// Item channel (item_valid / item_stall / item): a transaction with op clear
// empties the obstacle table, op append adds one obstacle, op point scores a
// trajectory point against every stored obstacle. Clear and append finish in
// the accept cycle. A point is scored one obstacle at a time out of the table
// memory, through a 27-step square root and a 10-step quotient of the
// gaussian argument; the quotient and the exponential are skipped when the
// obstacle is in contact or too far to contribute. A last point then runs the
// averaging divider and the result transaction, or only the result
// transaction after a collision or with an empty table.
// Result channel (result_valid / result_stall / result): one transaction per
// last point. The result register holds while result_stall is high; the
// block keeps scoring, and waits only when a new result is ready.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): ready is
// always high; write only while no point is in flight.
// Reset (rst, synchronous): empties the table, clears the trajectory and
// sets robot_radius and risk_factor to 1.0.
`timescale 1ns / 1ps

module dynamic_obstacle_collision_cost #(
  parameter int MAX_OBSTACLES = docc_pkg::MAX_OBSTACLES_DEF,
  parameter int MAX_POINTS    = docc_pkg::MAX_POINTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  docc_pkg::item_t                  item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output docc_pkg::result_t                result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [docc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [docc_pkg::LEN_W-1:0]       cfg_data
);

  docc_pkg::ctrl_cmd_t cmd;
  docc_pkg::ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  docc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  docc_datapath #(
    .MAX_OBSTACLES (MAX_OBSTACLES),
    .MAX_POINTS    (MAX_POINTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

[rtl/core/docc_datapath.sv]
`timescale 1ns / 1ps
`include "dynamic_obstacle_collision_cost_assert.svh"

module docc_datapath #(
  parameter int MAX_OBSTACLES = docc_pkg::MAX_OBSTACLES_DEF,
  parameter int MAX_POINTS    = docc_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  docc_pkg::item_t                     item,
  input  logic                                cfg_valid,
  input  logic [docc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [docc_pkg::LEN_W-1:0]          cfg_data,
  input  docc_pkg::ctrl_cmd_t                 cmd,
  output docc_pkg::ctrl_sts_t                 sts,
  input  logic                                result_stall,
  output logic                                result_valid,
  output docc_pkg::result_t                   result
);

  localparam int OCW = $clog2(MAX_OBSTACLES + 1);
  localparam int IW  = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int PCW = $clog2(MAX_POINTS + 1);
  localparam int DW  = OCW + PCW;

  localparam int POS_W   = docc_pkg::POS_W;
  localparam int LEN_W   = docc_pkg::LEN_W;
  localparam int TIME_W  = docc_pkg::TIME_W;
  localparam int SUM_W   = docc_pkg::SUM_W;
  localparam int MV_W    = docc_pkg::MV_W;
  localparam int DIFF_W  = docc_pkg::DIFF_W;
  localparam int SQ_W    = docc_pkg::SQ_W;
  localparam int RAD_W   = docc_pkg::RAD_W;
  localparam int ROOT_W  = docc_pkg::ROOT_W;
  localparam int REM_W   = docc_pkg::REM_W;
  localparam int CLR_W   = docc_pkg::CLR_W;
  localparam int A_W     = docc_pkg::A_W;
  localparam int U_W     = docc_pkg::U_W;
  localparam int TERM_W  = docc_pkg::TERM_W;
  localparam int EXPP_W  = docc_pkg::EXPP_W;
  localparam int FPROD_W = docc_pkg::FPROD_W;
  localparam int FQ_W    = docc_pkg::FQ_W;
  localparam int COST_W  = docc_pkg::COST_W;

  docc_pkg::obstacle_t mem [MAX_OBSTACLES];
  docc_pkg::obstacle_t rd;

  logic [LEN_W-1:0]  robot_radius;
  logic [LEN_W-1:0]  risk_factor;
  logic [OCW-1:0]    count;
  logic [IW-1:0]     idx;
  logic signed [POS_W-1:0] pt_x;
  logic signed [POS_W-1:0] pt_y;
  logic [TIME_W-1:0] pt_t;
  logic              pt_last;
  logic signed [MV_W-1:0]   mvx;
  logic signed [MV_W-1:0]   mvy;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic [SQ_W-1:0]   sqx;
  logic [SQ_W-1:0]   sqy;
  logic [RAD_W-1:0]  rad;
  logic [ROOT_W-1:0] root;
  logic [REM_W-1:0]  rem;
  logic [LEN_W-1:0]  grem;
  logic [A_W-1:0]    gsh;
  logic [U_W-1:0]    u;
  logic [TERM_W-1:0] term;
  logic [SUM_W-1:0]  sum;
  logic [PCW-1:0]    points;
  logic              hit;
  logic [FQ_W-1:0]   fq;
  logic [DW-1:0]     frem;
  logic [DW-1:0]     den;

  logic signed [MV_W-1:0]  vx_ext, vy_ext, t_ext;
  logic signed [SQ_W-1:0]  dx_ext, dy_ext;
  logic [REM_W+1:0]        rem_sh, trial;
  logic [CLR_W-1:0]        clr;
  logic                    clr_pos;
  logic [LEN_W-1:0]        sig;
  logic                    far;
  logic [LEN_W:0]          gt;
  logic                    gge;
  logic [U_W-1:0]          a_ext;
  logic [EXPP_W-1:0]       ei_ext, ef_ext, exp_prod;
  logic [SUM_W:0]          sum_add;
  logic [FPROD_W-1:0]      sum_ext, risk_ext, fprod;
  logic [DW-1:0]           cnt_ext, pts_ext;
  logic [DW:0]             fsh;
  logic                    fge;
  logic [COST_W-1:0]       fq_sat;
  logic                    idx_last;

  always_comb begin
    vx_ext   = MV_W'(rd.vx);
    vy_ext   = MV_W'(rd.vy);
    t_ext    = $signed({{(MV_W-TIME_W){1'b0}}, pt_t});
    dx_ext   = SQ_W'(dx);
    dy_ext   = SQ_W'(dy);
    rem_sh   = {rem, rad[RAD_W-1:RAD_W-2]};
    trial    = (REM_W+2)'({root, 2'b01});
    clr      = CLR_W'(root) - CLR_W'(robot_radius) - CLR_W'(rd.radius);
    clr_pos  = !clr[CLR_W-1] && (clr != '0);
    sig      = (rd.spread == '0) ? LEN_W'(1) : rd.spread;
    far      = clr >= CLR_W'({sig, 2'b00});
    gt       = {grem, gsh[A_W-1]};
    gge      = gt >= (LEN_W+1)'(sig);
    a_ext    = U_W'(gsh);
    ei_ext   = EXPP_W'(docc_pkg::exp_int(u[U_W-1:U_W-4]));
    ef_ext   = EXPP_W'(docc_pkg::exp_frac(u[U_W-5:U_W-8]));
    exp_prod = ei_ext * ef_ext + docc_pkg::EXP_ROUND;
    sum_add  = (SUM_W+1)'(sum) + (SUM_W+1)'(term);
    sum_ext  = FPROD_W'(sum);
    risk_ext = FPROD_W'(risk_factor);
    fprod    = sum_ext * risk_ext;
    cnt_ext  = DW'(count);
    pts_ext  = DW'(points);
    fsh      = {frem, fq[FQ_W-1]};
    fge      = fsh >= (DW+1)'(den);
    fq_sat   = (fq[FQ_W-1:COST_W] != '0) ? docc_pkg::COST_MAX : fq[COST_W-1:0];
    idx_last = (OCW'(idx) + OCW'(1)) == count;
  end

  always_comb begin
    sts.item_op    = item.op;
    sts.item_last  = item.last_point;
    sts.count_zero = (count == '0);
    sts.idx_last   = idx_last;
    sts.skip       = !clr_pos || far;
    sts.pt_last    = pt_last;
    sts.hit        = hit;
    sts.out_free   = !result_valid || !result_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && item.op == docc_pkg::OP_APPEND && count < OCW'(MAX_OBSTACLES)) begin
      mem[count[IW-1:0]] <= '{x: item.pos_x, y: item.pos_y, vx: item.vel_x,
                              vy: item.vel_y, radius: item.obstacle_radius,
                              spread: item.obstacle_spread};
    end
    if (cmd.code == docc_pkg::CMD_READ) begin
      rd <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      robot_radius <= docc_pkg::ROBOT_RADIUS_RST;
      risk_factor  <= docc_pkg::RISK_FACTOR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        docc_pkg::CFG_ROBOT_RADIUS: robot_radius <= cfg_data;
        docc_pkg::CFG_RISK_FACTOR:  risk_factor  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      sum          <= '0;
      points       <= '0;
      hit          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.code == docc_pkg::CMD_EMIT) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (cmd.accept) begin
        unique case (item.op)
          docc_pkg::OP_CLEAR: begin
            count  <= '0;
            sum    <= '0;
            points <= '0;
            hit    <= 1'b0;
          end
          docc_pkg::OP_APPEND: begin
            if (count < OCW'(MAX_OBSTACLES)) begin
              count <= count + OCW'(1);
            end
          end
          docc_pkg::OP_POINT: begin
            pt_x    <= item.pos_x;
            pt_y    <= item.pos_y;
            pt_t    <= item.point_time;
            pt_last <= item.last_point;
            idx     <= '0;
          end
          default: ;
        endcase
      end else begin
        case (cmd.code)
          docc_pkg::CMD_MOVE: begin
            mvx <= vx_ext * t_ext;
            mvy <= vy_ext * t_ext;
          end
          docc_pkg::CMD_DIFF: begin
            dx <= DIFF_W'(rd.x) + DIFF_W'(mvx >>> 8) - DIFF_W'(pt_x);
            dy <= DIFF_W'(rd.y) + DIFF_W'(mvy >>> 8) - DIFF_W'(pt_y);
          end
          docc_pkg::CMD_SQUARE: begin
            sqx <= dx_ext * dx_ext;
            sqy <= dy_ext * dy_ext;
          end
          docc_pkg::CMD_ROOT_LD: begin
            rad  <= RAD_W'(sqx) + RAD_W'(sqy);
            root <= '0;
            rem  <= '0;
          end
          docc_pkg::CMD_ROOT_STEP: begin
            rad <= rad << 2;
            if (rem_sh >= trial) begin
              rem  <= REM_W'(rem_sh - trial);
              root <= {root[ROOT_W-2:0], 1'b1};
            end else begin
              rem  <= REM_W'(rem_sh);
              root <= {root[ROOT_W-2:0], 1'b0};
            end
          end
          docc_pkg::CMD_EVAL: begin
            if (!clr_pos) begin
              hit <= 1'b1;
            end
            term <= '0;
            grem <= clr[LEN_W+1:2];
            gsh  <= {clr[1:0], {(A_W-2){1'b0}}};
          end
          docc_pkg::CMD_QSTEP: begin
            grem <= gge ? LEN_W'(gt - (LEN_W+1)'(sig)) : gt[LEN_W-1:0];
            gsh  <= {gsh[A_W-2:0], gge};
          end
          docc_pkg::CMD_EXP_SQ: begin
            u <= a_ext * a_ext;
          end
          docc_pkg::CMD_EXP_MUL: begin
            term <= (u >= docc_pkg::U_LIMIT) ? '0 : exp_prod[TERM_W+15:16];
          end
          docc_pkg::CMD_ACC: begin
            sum <= sum_add[SUM_W] ? docc_pkg::SUM_MAX : sum_add[SUM_W-1:0];
            if (idx_last) begin
              if (points < PCW'(MAX_POINTS)) begin
                points <= points + PCW'(1);
              end
            end else begin
              idx <= idx + IW'(1);
            end
          end
          docc_pkg::CMD_FMUL: begin
            fq   <= fprod[FPROD_W-1:8];
            den  <= cnt_ext * pts_ext;
            frem <= '0;
          end
          docc_pkg::CMD_FSTEP: begin
            frem <= fge ? DW'(fsh - (DW+1)'(den)) : fsh[DW-1:0];
            fq   <= {fq[FQ_W-2:0], fge};
          end
          docc_pkg::CMD_EMIT: begin
            result.collision <= (count != '0) && hit;
            if (count == '0) begin
              result.path_cost <= '0;
            end else if (hit) begin
              result.path_cost <= docc_pkg::COLLISION_COST;
            end else begin
              result.path_cost <= fq_sat;
            end
            sum    <= '0;
            points <= '0;
            hit    <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  `DOCC_ASSERT_NEXT(a_emit_shows, clk, rst, cmd.code == docc_pkg::CMD_EMIT, result_valid)
  `DOCC_ASSERT_IMPLY(a_points_cap, clk, rst, 1'b1, points <= PCW'(MAX_POINTS))

endmodule

[rtl/core/docc_ctrl.sv]
`timescale 1ns / 1ps
`include "dynamic_obstacle_collision_cost_assert.svh"

module docc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  docc_pkg::ctrl_sts_t sts,
  output docc_pkg::ctrl_cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_READ    = 4'd1;
  localparam logic [3:0] S_MOVE    = 4'd2;
  localparam logic [3:0] S_DIFF    = 4'd3;
  localparam logic [3:0] S_SQUARE  = 4'd4;
  localparam logic [3:0] S_ROOT_LD = 4'd5;
  localparam logic [3:0] S_ROOT    = 4'd6;
  localparam logic [3:0] S_EVAL    = 4'd7;
  localparam logic [3:0] S_QDIV    = 4'd8;
  localparam logic [3:0] S_EXP_SQ  = 4'd9;
  localparam logic [3:0] S_EXP_MUL = 4'd10;
  localparam logic [3:0] S_ACC     = 4'd11;
  localparam logic [3:0] S_FMUL    = 4'd12;
  localparam logic [3:0] S_FDIV    = 4'd13;
  localparam logic [3:0] S_EMIT    = 4'd14;

  localparam int STEP_W = docc_pkg::STEP_W;

  logic [3:0]        state, state_next;
  logic [STEP_W-1:0] cnt, cnt_next;
  logic              accept;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;

  always_comb begin
    cmd.accept = accept;
    cmd.code   = docc_pkg::CMD_NONE;
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      S_IDLE: begin
        if (accept && sts.item_op == docc_pkg::OP_POINT) begin
          if (!sts.count_zero) begin
            state_next = S_READ;
          end else if (sts.item_last) begin
            state_next = S_EMIT;
          end
        end
      end
      S_READ: begin
        cmd.code   = docc_pkg::CMD_READ;
        state_next = S_MOVE;
      end
      S_MOVE: begin
        cmd.code   = docc_pkg::CMD_MOVE;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.code   = docc_pkg::CMD_DIFF;
        state_next = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.code   = docc_pkg::CMD_SQUARE;
        state_next = S_ROOT_LD;
      end
      S_ROOT_LD: begin
        cmd.code   = docc_pkg::CMD_ROOT_LD;
        cnt_next   = docc_pkg::ROOT_STEPS - STEP_W'(1);
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.code = docc_pkg::CMD_ROOT_STEP;
        cnt_next = cnt - STEP_W'(1);
        if (cnt == '0) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.code = docc_pkg::CMD_EVAL;
        cnt_next = docc_pkg::QDIV_STEPS - STEP_W'(1);
        state_next = sts.skip ? S_ACC : S_QDIV;
      end
      S_QDIV: begin
        cmd.code = docc_pkg::CMD_QSTEP;
        cnt_next = cnt - STEP_W'(1);
        if (cnt == '0) begin
          state_next = S_EXP_SQ;
        end
      end
      S_EXP_SQ: begin
        cmd.code   = docc_pkg::CMD_EXP_SQ;
        state_next = S_EXP_MUL;
      end
      S_EXP_MUL: begin
        cmd.code   = docc_pkg::CMD_EXP_MUL;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.code = docc_pkg::CMD_ACC;
        if (!sts.idx_last) begin
          state_next = S_READ;
        end else if (!sts.pt_last) begin
          state_next = S_IDLE;
        end else if (sts.hit) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_FMUL;
        end
      end
      S_FMUL: begin
        cmd.code   = docc_pkg::CMD_FMUL;
        cnt_next   = docc_pkg::FDIV_STEPS - STEP_W'(1);
        state_next = S_FDIV;
      end
      S_FDIV: begin
        cmd.code = docc_pkg::CMD_FSTEP;
        cnt_next = cnt - STEP_W'(1);
        if (cnt == '0) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.code   = docc_pkg::CMD_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  `DOCC_ASSERT_NEXT(a_root_done, clk, rst, state == S_ROOT && cnt == '0, state == S_EVAL)
  `DOCC_ASSERT_NEXT(a_fdiv_done, clk, rst, state == S_FDIV && cnt == '0, state == S_EMIT)
  `DOCC_ASSERT_NEXT(a_emit_idle, clk, rst, state == S_EMIT && sts.out_free, state == S_IDLE)

endmodule
